// File: rtl/vgm_pkg.sv
// ----------------------------------------------------------------------------
// Voxel grid package
// Shared constants, codes and control types of the voxel occupancy grid.
// ----------------------------------------------------------------------------
package vgm_pkg;

	localparam int MAX_DIM    = 64;
	localparam int DIM_W      = 6;
	localparam int CDIM_W     = 7;
	localparam int ROW_W      = 2 * DIM_W;
	localparam int ROWS       = MAX_DIM * MAX_DIM;
	localparam int MAX_MARGIN = 4;
	localparam int MRG_W      = 3;
	localparam int OFS_W      = 4;
	localparam int COORD_W    = 32;
	localparam int FRAC_BITS  = 16;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 32;
	localparam int PADDR_W    = 5;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_INSERT = 2'd0;
	localparam opcode_t OP_QUERY  = 2'd1;
	localparam opcode_t OP_CLEAR  = 2'd2;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_ORIGIN_X = 3'd0;
	localparam reg_idx_t REG_ORIGIN_Y = 3'd1;
	localparam reg_idx_t REG_ORIGIN_Z = 3'd2;
	localparam reg_idx_t REG_INV_SIZE = 3'd3;
	localparam reg_idx_t REG_DIM_X    = 3'd4;
	localparam reg_idx_t REG_DIM_Y    = 3'd5;
	localparam reg_idx_t REG_DIM_Z    = 3'd6;
	localparam reg_idx_t REG_MARGIN   = 3'd7;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MAG, S_MUL, S_CHK,
		S_SH_RD, S_SH_WR, S_Q_RD, S_Q_CAP, S_Q_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic mag;
		logic mul;
		logic chk;
		logic sh_adv;
		logic sh_wr;
		logic q_rd;
		logic q_cap;
		logic out_ld;
		logic clr_wr;
	} cmd_t;

	typedef struct packed {
		logic ax_ok;
		logic ax_last;
		logic row_ok;
		logic sh_last;
		logic q_last;
		logic clr_last;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic [COORD_W-1:0] origin_x;
		logic [COORD_W-1:0] origin_y;
		logic [COORD_W-1:0] origin_z;
		logic [COORD_W-1:0] inv_voxel_size;
		logic [CDIM_W-1:0]  dim_x;
		logic [CDIM_W-1:0]  dim_y;
		logic [CDIM_W-1:0]  dim_z;
		logic [MRG_W-1:0]   margin;
	} cfg_t;

	function automatic logic [CDIM_W-1:0] sat_dim(input logic [CDIM_W-1:0] d);
		sat_dim = (d > CDIM_W'(MAX_DIM)) ? CDIM_W'(MAX_DIM) : d;
	endfunction

endpackage

// File: rtl/vgm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vgm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/vgm_ctrl.sv
// ----------------------------------------------------------------------------
// Voxel grid controller
// Sequences clear sweeps, point inserts and face queries.
// ----------------------------------------------------------------------------
module vgm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  vgm_pkg::opcode_t opcode,
	output logic             in_ready,
	input  vgm_pkg::stat_t   st,
	output vgm_pkg::cmd_t    cmd
);

	vgm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vgm_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			vgm_pkg::S_CLEAR: if (st.clr_last) state_d = vgm_pkg::S_IDLE;
			vgm_pkg::S_IDLE: begin
				if (in_valid) begin
					case (opcode)
						vgm_pkg::OP_INSERT: state_d = vgm_pkg::S_MAG;
						vgm_pkg::OP_QUERY:  state_d = vgm_pkg::S_Q_RD;
						vgm_pkg::OP_CLEAR:  state_d = vgm_pkg::S_CLEAR;
						default:            state_d = vgm_pkg::S_IDLE;
					endcase
				end
			end
			vgm_pkg::S_MAG: state_d = vgm_pkg::S_MUL;
			vgm_pkg::S_MUL: state_d = vgm_pkg::S_CHK;
			vgm_pkg::S_CHK: begin
				if (!st.ax_ok) state_d = vgm_pkg::S_IDLE;
				else if (st.ax_last) state_d = vgm_pkg::S_SH_RD;
				else state_d = vgm_pkg::S_MAG;
			end
			vgm_pkg::S_SH_RD: begin
				if (st.row_ok) state_d = vgm_pkg::S_SH_WR;
				else if (st.sh_last) state_d = vgm_pkg::S_IDLE;
			end
			vgm_pkg::S_SH_WR: state_d = st.sh_last ? vgm_pkg::S_IDLE : vgm_pkg::S_SH_RD;
			vgm_pkg::S_Q_RD: state_d = vgm_pkg::S_Q_CAP;
			vgm_pkg::S_Q_CAP: state_d = st.q_last ? vgm_pkg::S_Q_OUT : vgm_pkg::S_Q_RD;
			vgm_pkg::S_Q_OUT: if (st.out_free) state_d = vgm_pkg::S_IDLE;
			default: state_d = vgm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			vgm_pkg::S_CLEAR: cmd.clr_wr = 1'b1;
			vgm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			vgm_pkg::S_MAG:   cmd.mag = 1'b1;
			vgm_pkg::S_MUL:   cmd.mul = 1'b1;
			vgm_pkg::S_CHK:   cmd.chk = 1'b1;
			vgm_pkg::S_SH_RD: cmd.sh_adv = !st.row_ok;
			vgm_pkg::S_SH_WR: begin
				cmd.sh_adv = 1'b1;
				cmd.sh_wr  = 1'b1;
			end
			vgm_pkg::S_Q_RD:  cmd.q_rd = 1'b1;
			vgm_pkg::S_Q_CAP: cmd.q_cap = 1'b1;
			vgm_pkg::S_Q_OUT: cmd.out_ld = st.out_free;
			default: cmd = '0;
		endcase
	end

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vgm_pkg::S_CLEAR |-> !in_ready)
		else $error("input taken during clear sweep");
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> st.out_free)
		else $error("result loaded over a pending one");
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sh_wr |-> $past(state_q == vgm_pkg::S_SH_RD))
		else $error("row written without a read");

endmodule

// File: rtl/vgm_dp.sv
// ----------------------------------------------------------------------------
// Voxel grid datapath
// Index arithmetic, shell walk, grid memory, face logic and result register.
// ----------------------------------------------------------------------------
module vgm_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vgm_pkg::cfg_t                   cfg,
	input  vgm_pkg::cmd_t                   cmd,
	output vgm_pkg::stat_t                  st,
	input  logic [vgm_pkg::IN_DATA_W-1:0]   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [vgm_pkg::OUT_DATA_W-1:0]  out_data
);

	localparam int DW = vgm_pkg::DIM_W;
	localparam int CW = vgm_pkg::CDIM_W;
	localparam int XW = vgm_pkg::COORD_W;
	localparam int OW = vgm_pkg::OFS_W;

	logic [XW-1:0] pos_q [3];
	logic [DW-1:0] vox_q [3];
	logic [DW-1:0] idx_q [3];
	logic [1:0]    ax_q;
	logic [XW-1:0] mag_q;
	logic          neg_q;
	logic [vgm_pkg::PROD_W-1:0] prod_q;
	logic signed [OW-1:0] a_q, b_q;
	logic [2:0]    qk_q;
	logic [vgm_pkg::ROW_W-1:0] clr_q;
	logic [vgm_pkg::MAX_DIM-1:0] rc_q, rxm_q, rxp_q, ryp_q, rym_q;
	logic          out_valid_q;
	logic [vgm_pkg::OUT_DATA_W-1:0] out_q;

	logic [CW-1:0] dim_e [3];
	logic [XW-1:0] org;
	logic signed [XW:0] diff;
	logic [vgm_pkg::PROD_W-1:0] ip;
	logic [vgm_pkg::MRG_W-1:0] m_e;
	logic signed [OW-1:0] m_s;
	logic [OW-1:0] abs_a, abs_b;
	logic signed [OW+1:0] r;
	logic signed [DW+1:0] nx, ny, zp, zn;
	logic zp_ok, zn_ok;
	logic [vgm_pkg::MAX_DIM-1:0] row_mask;
	logic [vgm_pkg::ROW_W-1:0] sh_addr, q_addr, raddr, waddr;
	logic [vgm_pkg::MAX_DIM-1:0] rdata, wdata;
	logic we;
	logic [DW-1:0] qx, qy, qz;
	logic q_in, occ;
	logic [5:0] face;

	assign dim_e[0] = vgm_pkg::sat_dim(cfg.dim_x);
	assign dim_e[1] = vgm_pkg::sat_dim(cfg.dim_y);
	assign dim_e[2] = vgm_pkg::sat_dim(cfg.dim_z);
	assign m_e = (cfg.margin > vgm_pkg::MRG_W'(vgm_pkg::MAX_MARGIN)) ?
		vgm_pkg::MRG_W'(vgm_pkg::MAX_MARGIN) : cfg.margin;
	assign m_s = signed'({1'b0, m_e});

	always_comb begin
		case (ax_q)
			2'd0:    org = cfg.origin_x;
			2'd1:    org = cfg.origin_y;
			default: org = cfg.origin_z;
		endcase
	end

	assign diff = signed'({pos_q[ax_q][XW-1], pos_q[ax_q]}) - signed'({org[XW-1], org});
	assign ip   = prod_q >> (2 * vgm_pkg::FRAC_BITS);

	assign st.ax_ok = !(neg_q && ip != '0) && ip[vgm_pkg::PROD_W-1:CW] == '0 &&
		ip[CW-1:0] < dim_e[ax_q];
	assign st.ax_last = ax_q == 2'd2;

	assign abs_a = a_q[OW-1] ? OW'(-a_q) : OW'(a_q);
	assign abs_b = b_q[OW-1] ? OW'(-b_q) : OW'(b_q);
	assign r  = signed'({2'b0, m_s}) - signed'({2'b0, abs_a}) - signed'({2'b0, abs_b});
	assign nx = signed'({2'b0, idx_q[0]}) + (DW+2)'(a_q);
	assign ny = signed'({2'b0, idx_q[1]}) + (DW+2)'(b_q);
	assign zp = signed'({2'b0, idx_q[2]}) + (DW+2)'(r);
	assign zn = signed'({2'b0, idx_q[2]}) - (DW+2)'(r);
	assign zp_ok = zp >= 0 && zp < signed'({1'b0, dim_e[2]});
	assign zn_ok = zn >= 0 && zn < signed'({1'b0, dim_e[2]});
	assign row_mask = (zp_ok ? (vgm_pkg::MAX_DIM)'(1) << zp[DW-1:0] : '0) |
		(zn_ok ? (vgm_pkg::MAX_DIM)'(1) << zn[DW-1:0] : '0);
	assign st.row_ok = r >= 0 && nx >= 0 && ny >= 0 &&
		nx < signed'({1'b0, dim_e[0]}) && ny < signed'({1'b0, dim_e[1]});
	assign st.sh_last = a_q == m_s && b_q == m_s;
	assign sh_addr = {nx[DW-1:0], ny[DW-1:0]};

	assign qx = vox_q[0];
	assign qy = vox_q[1];
	assign qz = vox_q[2];
	always_comb begin
		case (qk_q)
			3'd0:    q_addr = {qx, qy};
			3'd1:    q_addr = {qx - DW'(1), qy};
			3'd2:    q_addr = {qx + DW'(1), qy};
			3'd3:    q_addr = {qx, qy + DW'(1)};
			default: q_addr = {qx, qy - DW'(1)};
		endcase
	end
	assign st.q_last   = qk_q == 3'd4;
	assign st.clr_last = &clr_q;
	assign st.out_free = !out_valid_q || out_ready;

	assign raddr = cmd.q_rd ? q_addr : sh_addr;
	assign we    = cmd.clr_wr || cmd.sh_wr;
	assign waddr = cmd.clr_wr ? clr_q : sh_addr;
	assign wdata = cmd.clr_wr ? '0 : (rdata | row_mask);

	vgm_ram #(.WIDTH(vgm_pkg::MAX_DIM), .DEPTH(vgm_pkg::ROWS)) u_grid (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign q_in = {1'b0, qx} < dim_e[0] && {1'b0, qy} < dim_e[1] && {1'b0, qz} < dim_e[2];
	assign occ  = q_in && rc_q[qz];
	always_comb begin
		face[0] = qz == '0 || !rc_q[qz - DW'(1)];
		face[1] = qx == '0 || !rxm_q[qz];
		face[2] = ({1'b0, qx} + CW'(1)) >= dim_e[0] || !rxp_q[qz];
		face[3] = ({1'b0, qz} + CW'(1)) >= dim_e[2] || !rc_q[qz + DW'(1)];
		face[4] = ({1'b0, qy} + CW'(1)) >= dim_e[1] || !ryp_q[qz];
		face[5] = qy == '0 || !rym_q[qz];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q[0] <= in_data[31:0];
			pos_q[1] <= in_data[63:32];
			pos_q[2] <= in_data[95:64];
			vox_q[0] <= in_data[101:96];
			vox_q[1] <= in_data[107:102];
			vox_q[2] <= in_data[113:108];
			ax_q     <= '0;
			qk_q     <= '0;
		end
		if (cmd.mag) begin
			neg_q <= diff[XW];
			mag_q <= diff[XW] ? XW'(-diff) : XW'(diff);
		end
		if (cmd.mul) prod_q <= mag_q * cfg.inv_voxel_size;
		if (cmd.chk) begin
			idx_q[ax_q] <= ip[DW-1:0];
			ax_q        <= ax_q + 2'd1;
			a_q         <= -m_s;
			b_q         <= -m_s;
		end
		if (cmd.sh_adv) begin
			if (b_q == m_s) begin
				b_q <= -m_s;
				a_q <= a_q + OW'(1);
			end else begin
				b_q <= b_q + OW'(1);
			end
		end
		if (cmd.q_cap) begin
			case (qk_q)
				3'd0:    rc_q  <= rdata;
				3'd1:    rxm_q <= rdata;
				3'd2:    rxp_q <= rdata;
				3'd3:    ryp_q <= rdata;
				default: rym_q <= rdata;
			endcase
			qk_q <= qk_q + 3'd1;
		end
		if (cmd.out_ld) begin
			out_q <= {7'd0, qz, qy, qx, (occ ? face : 6'd0), occ};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/voxel_grid_mark_and_face_cull_top.sv
// ----------------------------------------------------------------------------
// Voxel grid mark and face cull
// Occupancy grid with point insert, face query and clear, APB configured.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Contents
// s_axis    in         tvalid/tready        one operation item
// m_axis    out        tvalid/tready        one query result item
// apb       in/out     psel/penable/pready  eight configuration registers
//
// After reset a clear pass walks the 4096 grid rows, one a cycle, before the
// first item is taken. A clear item walks the rows the same way. A query
// makes five row reads of the grid memory. An insert steps each axis
// through magnitude, multiply and check on one shared multiplier, then
// walks the shell rows, a read and then a write for each row in the grid.
// A stalled result sits in the output register while the next item is taken.
module voxel_grid_mark_and_face_cull_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// pos_x[31:0], pos_y[63:32], pos_z[95:64], vox_x[101:96], vox_y[107:102],
	// vox_z[113:108], zero fill.
	input  logic [vgm_pkg::IN_DATA_W-1:0]          s_axis_tdata,
	// opcode[1:0].
	input  logic [1:0]                             s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// occupied[0], face_mask[6:1], res_x[12:7], res_y[18:13], res_z[24:19].
	output logic [vgm_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [vgm_pkg::PADDR_W-1:0]            paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);

	vgm_pkg::cfg_t   cfg_q;
	vgm_pkg::cmd_t   cmd;
	vgm_pkg::stat_t  st;
	vgm_pkg::reg_idx_t ridx;
	logic wr;

	assign pready = 1'b1;
	assign ridx   = paddr[vgm_pkg::PADDR_W-1:2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x       <= '0;
			cfg_q.origin_y       <= '0;
			cfg_q.origin_z       <= '0;
			cfg_q.inv_voxel_size <= 32'd6553600;
			cfg_q.dim_x          <= 7'd64;
			cfg_q.dim_y          <= 7'd64;
			cfg_q.dim_z          <= 7'd64;
			cfg_q.margin         <= 3'd1;
		end else if (wr) begin
			case (ridx)
				vgm_pkg::REG_ORIGIN_X: cfg_q.origin_x       <= pwdata;
				vgm_pkg::REG_ORIGIN_Y: cfg_q.origin_y       <= pwdata;
				vgm_pkg::REG_ORIGIN_Z: cfg_q.origin_z       <= pwdata;
				vgm_pkg::REG_INV_SIZE: cfg_q.inv_voxel_size <= pwdata;
				vgm_pkg::REG_DIM_X:    cfg_q.dim_x          <= pwdata[6:0];
				vgm_pkg::REG_DIM_Y:    cfg_q.dim_y          <= pwdata[6:0];
				vgm_pkg::REG_DIM_Z:    cfg_q.dim_z          <= pwdata[6:0];
				default:               cfg_q.margin         <= pwdata[2:0];
			endcase
		end
	end

	always_comb begin
		case (ridx)
			vgm_pkg::REG_ORIGIN_X: prdata = cfg_q.origin_x;
			vgm_pkg::REG_ORIGIN_Y: prdata = cfg_q.origin_y;
			vgm_pkg::REG_ORIGIN_Z: prdata = cfg_q.origin_z;
			vgm_pkg::REG_INV_SIZE: prdata = cfg_q.inv_voxel_size;
			vgm_pkg::REG_DIM_X:    prdata = {25'd0, cfg_q.dim_x};
			vgm_pkg::REG_DIM_Y:    prdata = {25'd0, cfg_q.dim_y};
			vgm_pkg::REG_DIM_Z:    prdata = {25'd0, cfg_q.dim_z};
			default:               prdata = {29'd0, cfg_q.margin};
		endcase
	end

	vgm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.opcode   (s_axis_tuser),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	vgm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.st        (st),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
